FILE: hw/rtl/tlsp_pkg.sv
// types and constants shared by the terminal locator sequence parser
package tlsp_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LOC_W  = 13;
   localparam int unsigned DATA_W = 40;
   localparam int unsigned PAD_W  = DATA_W - BYTE_W - 2 * LOC_W;

   localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
   localparam logic [BYTE_W-1:0] CH_LBR   = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;
   localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;
   localparam logic [BYTE_W-1:0] CH_W     = 8'h77;
   localparam logic [BYTE_W-1:0] CH_M     = 8'h4D;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

   localparam logic [LOC_W-1:0] NUM_LIMIT = 13'd4096;
   localparam logic [LOC_W-1:0] XY_OFFSET = 13'd33;
   localparam logic [LOC_W-1:0] DEC_OFFSET = 13'd1;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_LOC  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_D_OPEN,
      ST_D_PE,
      ST_D_PB,
      ST_D_PR,
      ST_D_PC,
      ST_D_PP,
      ST_D_W,
      ST_X_OPEN,
      ST_X_M,
      ST_X_B,
      ST_X_X,
      ST_X_Y,
      ST_RP_READ,
      ST_RP_SEND,
      ST_RP_LAST
   } state_type;

   typedef enum logic [1:0] {
      ACT_HOLD,
      ACT_FAIL,
      ACT_DONE,
      ACT_PASS
   } act_type;

   typedef struct packed {
      logic hold;
      logic set_digit;
      logic clr_digit;
      logic clr_accum;
      logic add_digit;
      logic save_row;
      logic save_col;
      logic emit_char;
      logic emit_x;
      logic emit_d;
      logic fail;
      logic rp_send;
      logic rp_last;
   } cmd_type;

   typedef struct packed {
      logic is_esc;
      logic is_lbr;
      logic is_semi;
      logic is_amp;
      logic is_w;
      logic is_m;
      logic is_digit;
      logic digit_seen;
      logic dec_mode;
      logic hold_full;
      logic rp_at_end;
      logic out_free;
   } stat_type;

endpackage

FILE: hw/rtl/tlsp_ctrl.sv
// sequence recognizer and replay controller
module tlsp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  tlsp_pkg::stat_type stat,
   output tlsp_pkg::cmd_type  cmd
);

   tlsp_pkg::state_type state_ff, state_in;
   tlsp_pkg::state_type dec_next;
   tlsp_pkg::act_type   dec_act;
   tlsp_pkg::cmd_type   dec_side;
   logic                replaying;
   logic                accept;

   assign replaying  = (state_ff == tlsp_pkg::ST_RP_READ) ||
                       (state_ff == tlsp_pkg::ST_RP_SEND) ||
                       (state_ff == tlsp_pkg::ST_RP_LAST);
   assign req_tready = !replaying && stat.out_free;
   assign accept     = req_tvalid && req_tready;

   // per-byte decision of the grammar
   always_comb begin
      dec_act  = tlsp_pkg::ACT_FAIL;
      dec_next = state_ff;
      dec_side = '0;
      unique case (state_ff)
         tlsp_pkg::ST_IDLE: begin
            if (stat.is_esc) begin
               dec_act  = tlsp_pkg::ACT_HOLD;
               dec_next = stat.dec_mode ? tlsp_pkg::ST_D_OPEN : tlsp_pkg::ST_X_OPEN;
            end else begin
               dec_act = tlsp_pkg::ACT_PASS;
            end
         end
         tlsp_pkg::ST_D_OPEN: begin
            if (stat.is_lbr) begin
               dec_act            = tlsp_pkg::ACT_HOLD;
               dec_next           = tlsp_pkg::ST_D_PE;
               dec_side.clr_digit = 1'b1;
            end
         end
         tlsp_pkg::ST_D_PE, tlsp_pkg::ST_D_PB: begin
            if (stat.is_digit) begin
               dec_act            = tlsp_pkg::ACT_HOLD;
               dec_side.set_digit = 1'b1;
            end else if (stat.is_semi && stat.digit_seen) begin
               dec_act            = tlsp_pkg::ACT_HOLD;
               dec_side.clr_digit = 1'b1;
               dec_side.clr_accum = 1'b1;
               dec_next = (state_ff == tlsp_pkg::ST_D_PE) ? tlsp_pkg::ST_D_PB
                                                          : tlsp_pkg::ST_D_PR;
            end
         end
         tlsp_pkg::ST_D_PR: begin
            if (stat.is_digit) begin
               dec_act            = tlsp_pkg::ACT_HOLD;
               dec_side.add_digit = 1'b1;
            end else if (stat.is_semi && stat.digit_seen) begin
               dec_act            = tlsp_pkg::ACT_HOLD;
               dec_side.save_row  = 1'b1;
               dec_side.clr_accum = 1'b1;
               dec_side.clr_digit = 1'b1;
               dec_next           = tlsp_pkg::ST_D_PC;
            end
         end
         tlsp_pkg::ST_D_PC: begin
            if (stat.is_digit) begin
               dec_act            = tlsp_pkg::ACT_HOLD;
               dec_side.add_digit = 1'b1;
            end else if (stat.is_amp && stat.digit_seen) begin
               dec_act  = tlsp_pkg::ACT_HOLD;
               dec_next = tlsp_pkg::ST_D_W;
            end else if (stat.is_semi && stat.digit_seen) begin
               dec_act  = tlsp_pkg::ACT_HOLD;
               dec_next = tlsp_pkg::ST_D_PP;
            end
         end
         tlsp_pkg::ST_D_PP: begin
            if (stat.is_digit) begin
               dec_act = tlsp_pkg::ACT_HOLD;
            end else if (stat.is_amp) begin
               dec_act  = tlsp_pkg::ACT_HOLD;
               dec_next = tlsp_pkg::ST_D_W;
            end
         end
         tlsp_pkg::ST_D_W: begin
            if (stat.is_w) begin
               dec_act = tlsp_pkg::ACT_DONE;
            end
         end
         tlsp_pkg::ST_X_OPEN: begin
            if (stat.is_lbr) begin
               dec_act  = tlsp_pkg::ACT_HOLD;
               dec_next = tlsp_pkg::ST_X_M;
            end
         end
         tlsp_pkg::ST_X_M: begin
            if (stat.is_m) begin
               dec_act  = tlsp_pkg::ACT_HOLD;
               dec_next = tlsp_pkg::ST_X_B;
            end
         end
         tlsp_pkg::ST_X_B: begin
            dec_act  = tlsp_pkg::ACT_HOLD;
            dec_next = tlsp_pkg::ST_X_X;
         end
         tlsp_pkg::ST_X_X: begin
            dec_act           = tlsp_pkg::ACT_HOLD;
            dec_side.save_col = 1'b1;
            dec_next          = tlsp_pkg::ST_X_Y;
         end
         tlsp_pkg::ST_X_Y: begin
            dec_act = tlsp_pkg::ACT_DONE;
         end
         default: begin
            dec_act = tlsp_pkg::ACT_FAIL;
         end
      endcase
      // a byte that cannot be held fails the sequence
      if (dec_act == tlsp_pkg::ACT_HOLD && stat.hold_full) begin
         dec_act = tlsp_pkg::ACT_FAIL;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlsp_pkg::ST_RP_READ: begin
            state_in = tlsp_pkg::ST_RP_SEND;
         end
         tlsp_pkg::ST_RP_SEND: begin
            if (stat.out_free) begin
               state_in = stat.rp_at_end ? tlsp_pkg::ST_RP_LAST : tlsp_pkg::ST_RP_READ;
            end
         end
         tlsp_pkg::ST_RP_LAST: begin
            if (stat.out_free) begin
               state_in = tlsp_pkg::ST_IDLE;
            end
         end
         default: begin
            if (accept) begin
               unique case (dec_act)
                  tlsp_pkg::ACT_HOLD: state_in = dec_next;
                  tlsp_pkg::ACT_FAIL: state_in = tlsp_pkg::ST_RP_READ;
                  tlsp_pkg::ACT_DONE: state_in = tlsp_pkg::ST_IDLE;
                  tlsp_pkg::ACT_PASS: state_in = tlsp_pkg::ST_IDLE;
                  default:            state_in = tlsp_pkg::ST_IDLE;
               endcase
            end
         end
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         tlsp_pkg::ST_RP_READ: begin
            cmd = '0;
         end
         tlsp_pkg::ST_RP_SEND: begin
            cmd.rp_send = stat.out_free;
         end
         tlsp_pkg::ST_RP_LAST: begin
            cmd.rp_last = stat.out_free;
         end
         default: begin
            if (accept) begin
               unique case (dec_act)
                  tlsp_pkg::ACT_HOLD: begin
                     cmd      = dec_side;
                     cmd.hold = 1'b1;
                  end
                  tlsp_pkg::ACT_FAIL: cmd.fail = 1'b1;
                  tlsp_pkg::ACT_DONE: begin
                     if (state_ff == tlsp_pkg::ST_X_Y) begin
                        cmd.emit_x = 1'b1;
                     end else begin
                        cmd.emit_d = 1'b1;
                     end
                  end
                  tlsp_pkg::ACT_PASS: cmd.emit_char = 1'b1;
                  default:            cmd = '0;
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlsp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/tlsp_dp.sv
// hold buffer, number accumulation and result register
module tlsp_dp #(
   parameter int unsigned HOLD_DEPTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic                            csr_wdata,
   input  logic [tlsp_pkg::BYTE_W-1:0]     req_tdata,
   input  tlsp_pkg::cmd_type               cmd,
   output tlsp_pkg::stat_type              stat,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [tlsp_pkg::DATA_W-1:0]     rsp_tdata,
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);

   localparam int unsigned AW = $clog2(HOLD_DEPTH);
   localparam int unsigned CW = $clog2(HOLD_DEPTH + 1);
   localparam int unsigned BW = tlsp_pkg::BYTE_W;
   localparam int unsigned LW = tlsp_pkg::LOC_W;

   logic [BW-1:0] mem [HOLD_DEPTH];
   logic [BW-1:0] rd_ff;

   logic          mode_ff, mode_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [LW-1:0] accum_ff, accum_in;
   logic          digit_ff, digit_in;
   logic [LW-1:0] row_ff, row_in;
   logic [BW-1:0] colb_ff, colb_in;
   logic [BW-1:0] fail_ff, fail_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_user_ff, rsp_user_in;
   logic [BW-1:0]        rsp_char_ff, rsp_char_in;
   logic signed [LW-1:0] rsp_row_ff, rsp_row_in;
   logic signed [LW-1:0] rsp_col_ff, rsp_col_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [16:0] times_ten;
   logic [LW-1:0] accum_sat;
   logic        seq_clear;

   assign seq_clear = cmd.emit_x || cmd.emit_d || cmd.rp_last;

   // accum * 10 + digit, saturating
   assign times_ten = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0}
                      + {13'd0, 4'(req_tdata - tlsp_pkg::CH_ZERO)};
   assign accum_sat = (times_ten > {4'd0, tlsp_pkg::NUM_LIMIT}) ? tlsp_pkg::NUM_LIMIT
                                                                : times_ten[LW-1:0];

   always_comb begin
      stat.is_esc     = (req_tdata == tlsp_pkg::CH_ESC);
      stat.is_lbr     = (req_tdata == tlsp_pkg::CH_LBR);
      stat.is_semi    = (req_tdata == tlsp_pkg::CH_SEMI);
      stat.is_amp     = (req_tdata == tlsp_pkg::CH_AMP);
      stat.is_w       = (req_tdata == tlsp_pkg::CH_W);
      stat.is_m       = (req_tdata == tlsp_pkg::CH_M);
      stat.is_digit   = (req_tdata >= tlsp_pkg::CH_ZERO) && (req_tdata <= tlsp_pkg::CH_NINE);
      stat.digit_seen = digit_ff;
      stat.dec_mode   = mode_ff;
      stat.hold_full  = (count_ff == CW'(HOLD_DEPTH));
      stat.rp_at_end  = ((CW'(idx_ff) + CW'(1)) == count_ff);
      stat.out_free   = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      mode_in = csr_we ? csr_wdata : mode_ff;

      count_in = count_ff;
      if (seq_clear) begin
         count_in = '0;
      end else if (cmd.hold) begin
         count_in = count_ff + CW'(1);
      end

      idx_in = idx_ff;
      if (cmd.fail) begin
         idx_in = '0;
      end else if (cmd.rp_send) begin
         idx_in = idx_ff + AW'(1);
      end

      accum_in = accum_ff;
      if (seq_clear || cmd.clr_accum) begin
         accum_in = '0;
      end else if (cmd.add_digit) begin
         accum_in = accum_sat;
      end

      digit_in = digit_ff;
      if (seq_clear || cmd.clr_digit) begin
         digit_in = 1'b0;
      end else if (cmd.set_digit || cmd.add_digit) begin
         digit_in = 1'b1;
      end

      row_in  = cmd.save_row ? accum_ff : row_ff;
      colb_in = cmd.save_col ? req_tdata : colb_ff;
      fail_in = cmd.fail ? req_tdata : fail_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in  = rsp_user_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_last_in  = rsp_last_ff;
      priority if (cmd.emit_char || cmd.rp_send || cmd.rp_last) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = tlsp_pkg::KIND_CHAR;
         rsp_row_in   = '0;
         rsp_col_in   = '0;
         rsp_last_in  = !cmd.rp_send;
         if (cmd.emit_char) begin
            rsp_char_in = req_tdata;
         end else if (cmd.rp_send) begin
            rsp_char_in = rd_ff;
         end else begin
            rsp_char_in = fail_ff;
         end
      end else if (cmd.emit_x) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = tlsp_pkg::KIND_LOC;
         rsp_char_in  = '0;
         rsp_row_in   = LW'(req_tdata) - tlsp_pkg::XY_OFFSET;
         rsp_col_in   = LW'(colb_ff) - tlsp_pkg::XY_OFFSET;
         rsp_last_in  = 1'b1;
      end else if (cmd.emit_d) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = tlsp_pkg::KIND_LOC;
         rsp_char_in  = '0;
         rsp_row_in   = row_ff - tlsp_pkg::DEC_OFFSET;
         rsp_col_in   = accum_ff - tlsp_pkg::DEC_OFFSET;
         rsp_last_in  = 1'b1;
      end else begin
         rsp_user_in = rsp_user_ff;
      end
   end

   // hold buffer
   always_ff @(posedge clock) begin
      if (cmd.hold) begin
         mem[count_ff[AW-1:0]] <= req_tdata;
      end
      rd_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         count_ff     <= '0;
         idx_ff       <= '0;
         accum_ff     <= '0;
         digit_ff     <= 1'b0;
         row_ff       <= '0;
         colb_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         accum_ff     <= accum_in;
         digit_ff     <= digit_in;
         row_ff       <= row_in;
         colb_ff      <= colb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fail_ff     <= fail_in;
      rsp_user_ff <= rsp_user_in;
      rsp_char_ff <= rsp_char_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{tlsp_pkg::PAD_W{1'b0}}, rsp_col_ff, rsp_row_ff, rsp_char_ff};

endmodule

FILE: hw/rtl/terminal_locator_sequence_parser.sv
// top level of the terminal locator sequence parser
//
//   channel  direction  handshake            payload
//   req_     in         req_tvalid/tready    tdata: in_byte
//   rsp_     out        rsp_tvalid/tready    tdata: char_value, loc_row, loc_col;
//                                            tuser: kind; tlast: last
//   csr_     in         csr_we               csr_wdata: terminal_kind
//
// one byte per cycle outside a replay; every byte needs the result register free
// or being taken in that cycle, whether or not it ends in a result.
// a failed sequence replays its held bytes, each through a read and a send state for the
// registered read of the hold buffer, then the failing byte; input stalls meanwhile.
// reset is synchronous; the hold buffer needs no clearing pass.
module terminal_locator_sequence_parser #(
   parameter int unsigned HOLD_DEPTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic                        csr_wdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [tlsp_pkg::BYTE_W-1:0] req_tdata,   // [7:0] in_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [tlsp_pkg::DATA_W-1:0] rsp_tdata,   // [7:0] char_value, [20:8] loc_row,
                                                    // [33:21] loc_col, [39:34] zero
   output logic                        rsp_tuser,   // [0] kind
   output logic                        rsp_tlast
);

   tlsp_pkg::cmd_type  cmd;
   tlsp_pkg::stat_type stat;

   tlsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tlsp_dp #(
      .HOLD_DEPTH (HOLD_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a request never lands while an untaken result still sits in the register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid || rsp_tready)
      else $error("request accepted over a pending result");

   // a failing byte leaves the input stalled for the first state of the replay
   a_replay_stall: assert property (@(posedge clock) disable iff (reset)
      cmd.fail |=> !req_tready)
      else $error("input accepted during replay");

   // a locator result is always the last result of its request
   a_loc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata[7:0] == '0)
      else $error("malformed locator result");

   // only one result source drives the register in a cycle
   a_one_source: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.emit_char, cmd.emit_x, cmd.emit_d, cmd.rp_send, cmd.rp_last}) <= 1)
      else $error("conflicting result commands");

endmodule

FILE: verif/terminal_locator_report_checker.sv
// checker that predicts the parser's responses from the accepted requests and compares them
module terminal_locator_report_checker #(
   parameter int unsigned HOLD_DEPTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic                        csr_wdata,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [tlsp_pkg::BYTE_W-1:0] req_tdata,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [tlsp_pkg::DATA_W-1:0] rsp_tdata,
   input  logic                        rsp_tuser,
   input  logic                        rsp_tlast,
   output int unsigned                 fail_count,
   output int unsigned                 pending,
   output int unsigned                 requests_seen,
   output int unsigned                 chars_seen,
   output int unsigned                 locs_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned BW = tlsp_pkg::BYTE_W;
   localparam int unsigned LW = tlsp_pkg::LOC_W;

   typedef struct {
      logic          kind;
      logic [BW-1:0] char_value;
      logic [LW-1:0] loc_row;
      logic [LW-1:0] loc_col;
      logic          last;
   } parser_result_type;

   parser_result_type    due_results[$];
   logic [BW-1:0]        held_q[$];
   tlsp_pkg::state_type  phase;
   logic                 dec_grammar;
   logic [LW-1:0]        number_accum;
   logic [LW-1:0]        saved_row;
   logic [BW-1:0]        saved_col_byte;
   logic                 digit_seen;
   int unsigned          errs;
   int unsigned          n_req;
   int unsigned          n_char;
   int unsigned          n_loc;

   task automatic queue_result(input logic kind, input logic [BW-1:0] ch,
                               input logic [LW-1:0] row, input logic [LW-1:0] col,
                               input logic last);
      parser_result_type r;
      r.kind       = kind;
      r.char_value = ch;
      r.loc_row    = row;
      r.loc_col    = col;
      r.last       = last;
      due_results.push_back(r);
   endtask

   task automatic clear_sequence;
      phase        = tlsp_pkg::ST_IDLE;
      held_q.delete();
      number_accum = '0;
      digit_seen   = 1'b0;
   endtask

   task automatic accumulate_digit(input logic [BW-1:0] b);
      int v;
      v = int'(number_accum) * 10 + int'(b) - int'(tlsp_pkg::CH_ZERO);
      number_accum = (v > int'(tlsp_pkg::NUM_LIMIT)) ? tlsp_pkg::NUM_LIMIT : LW'(v);
      digit_seen   = 1'b1;
   endtask

   task automatic parse_byte(input logic [BW-1:0] b);
      logic                dig;
      tlsp_pkg::act_type   act;
      tlsp_pkg::state_type nxt;
      logic [LW-1:0]       row;
      logic [LW-1:0]       col;
      dig = (b >= tlsp_pkg::CH_ZERO) && (b <= tlsp_pkg::CH_NINE);
      act = tlsp_pkg::ACT_FAIL;
      nxt = phase;
      case (phase)
         tlsp_pkg::ST_IDLE: begin
            if (b != tlsp_pkg::CH_ESC) begin
               queue_result(tlsp_pkg::KIND_CHAR, b, '0, '0, 1'b1);
               return;
            end
            act = tlsp_pkg::ACT_HOLD;
            nxt = dec_grammar ? tlsp_pkg::ST_D_OPEN : tlsp_pkg::ST_X_OPEN;
         end
         tlsp_pkg::ST_D_OPEN: begin
            if (b == tlsp_pkg::CH_LBR) begin
               act = tlsp_pkg::ACT_HOLD;
               nxt = tlsp_pkg::ST_D_PE;
               digit_seen = 1'b0;
            end
         end
         tlsp_pkg::ST_D_PE, tlsp_pkg::ST_D_PB: begin
            if (dig) begin
               act = tlsp_pkg::ACT_HOLD;
               digit_seen = 1'b1;
            end else if (b == tlsp_pkg::CH_SEMI && digit_seen) begin
               act = tlsp_pkg::ACT_HOLD;
               digit_seen = 1'b0;
               number_accum = '0;
               nxt = (phase == tlsp_pkg::ST_D_PE) ? tlsp_pkg::ST_D_PB : tlsp_pkg::ST_D_PR;
            end
         end
         tlsp_pkg::ST_D_PR: begin
            if (dig) begin
               act = tlsp_pkg::ACT_HOLD;
               accumulate_digit(b);
            end else if (b == tlsp_pkg::CH_SEMI && digit_seen) begin
               act = tlsp_pkg::ACT_HOLD;
               saved_row = number_accum;
               number_accum = '0;
               digit_seen = 1'b0;
               nxt = tlsp_pkg::ST_D_PC;
            end
         end
         tlsp_pkg::ST_D_PC: begin
            if (dig) begin
               act = tlsp_pkg::ACT_HOLD;
               accumulate_digit(b);
            end else if (b == tlsp_pkg::CH_AMP && digit_seen) begin
               act = tlsp_pkg::ACT_HOLD;
               nxt = tlsp_pkg::ST_D_W;
            end else if (b == tlsp_pkg::CH_SEMI && digit_seen) begin
               act = tlsp_pkg::ACT_HOLD;
               nxt = tlsp_pkg::ST_D_PP;
            end
         end
         tlsp_pkg::ST_D_PP: begin
            if (dig) begin
               act = tlsp_pkg::ACT_HOLD;
            end else if (b == tlsp_pkg::CH_AMP) begin
               act = tlsp_pkg::ACT_HOLD;
               nxt = tlsp_pkg::ST_D_W;
            end
         end
         tlsp_pkg::ST_D_W: begin
            if (b == tlsp_pkg::CH_W) act = tlsp_pkg::ACT_DONE;
         end
         tlsp_pkg::ST_X_OPEN: begin
            if (b == tlsp_pkg::CH_LBR) begin
               act = tlsp_pkg::ACT_HOLD;
               nxt = tlsp_pkg::ST_X_M;
            end
         end
         tlsp_pkg::ST_X_M: begin
            if (b == tlsp_pkg::CH_M) begin
               act = tlsp_pkg::ACT_HOLD;
               nxt = tlsp_pkg::ST_X_B;
            end
         end
         tlsp_pkg::ST_X_B: begin
            act = tlsp_pkg::ACT_HOLD;
            nxt = tlsp_pkg::ST_X_X;
         end
         tlsp_pkg::ST_X_X: begin
            act = tlsp_pkg::ACT_HOLD;
            saved_col_byte = b;
            nxt = tlsp_pkg::ST_X_Y;
         end
         tlsp_pkg::ST_X_Y: begin
            act = tlsp_pkg::ACT_DONE;
         end
         default: begin
            clear_sequence();
            queue_result(tlsp_pkg::KIND_CHAR, b, '0, '0, 1'b1);
            return;
         end
      endcase

      if (act == tlsp_pkg::ACT_HOLD) begin
         if (held_q.size() < HOLD_DEPTH) begin
            held_q.push_back(b);
            phase = nxt;
            return;
         end
         act = tlsp_pkg::ACT_FAIL;
      end

      if (act == tlsp_pkg::ACT_DONE) begin
         if (phase == tlsp_pkg::ST_X_Y) begin
            row = LW'(b) - tlsp_pkg::XY_OFFSET;
            col = LW'(saved_col_byte) - tlsp_pkg::XY_OFFSET;
         end else begin
            row = saved_row - tlsp_pkg::DEC_OFFSET;
            col = number_accum - tlsp_pkg::DEC_OFFSET;
         end
         clear_sequence();
         queue_result(tlsp_pkg::KIND_LOC, '0, row, col, 1'b1);
         return;
      end

      // failed sequence: held bytes come back first, then the byte that broke it
      foreach (held_q[i]) queue_result(tlsp_pkg::KIND_CHAR, held_q[i], '0, '0, 1'b0);
      queue_result(tlsp_pkg::KIND_CHAR, b, '0, '0, 1'b1);
      clear_sequence();
   endtask

   task automatic check_response;
      parser_result_type want;
      logic [BW-1:0]     got_char;
      logic [LW-1:0]     got_row;
      logic [LW-1:0]     got_col;
      got_char = rsp_tdata[BW-1:0];
      got_row  = rsp_tdata[BW +: LW];
      got_col  = rsp_tdata[BW+LW +: LW];
      if (due_results.size() == 0) begin
         errs++;
         $error("response with none due: kind %0d char %h row %0d col %0d last %0d",
                rsp_tuser, got_char, $signed(got_row), $signed(got_col), rsp_tlast);
         return;
      end
      want = due_results.pop_front();
      if (rsp_tuser !== want.kind) begin
         errs++;
         $error("kind: expected %0d, actual %0d", want.kind, rsp_tuser);
      end
      if (got_char !== want.char_value) begin
         errs++;
         $error("char_value: expected %h, actual %h", want.char_value, got_char);
      end
      if (got_row !== want.loc_row) begin
         errs++;
         $error("loc_row: expected %0d, actual %0d", $signed(want.loc_row), $signed(got_row));
      end
      if (got_col !== want.loc_col) begin
         errs++;
         $error("loc_col: expected %0d, actual %0d", $signed(want.loc_col), $signed(got_col));
      end
      if (rsp_tlast !== want.last) begin
         errs++;
         $error("last: expected %0d, actual %0d", want.last, rsp_tlast);
      end
      if (want.kind == tlsp_pkg::KIND_LOC) n_loc++;
      else n_char++;
   endtask

   initial begin
      errs   = 0;
      n_req  = 0;
      n_char = 0;
      n_loc  = 0;
      dec_grammar    = 1'b0;
      saved_row      = '0;
      saved_col_byte = '0;
      clear_sequence();
   end

   always @(posedge clock) begin
      if (reset) begin
         due_results.delete();
         dec_grammar    = 1'b0;
         saved_row      = '0;
         saved_col_byte = '0;
         clear_sequence();
      end else begin
         if (rsp_tvalid && rsp_tready) check_response();
         if (req_tvalid && req_tready) begin
            n_req++;
            parse_byte(req_tdata);
         end
         // a grammar write takes effect from the next request on
         if (csr_we) dec_grammar = csr_wdata;
      end
      fail_count    <= errs;
      pending       <= due_results.size();
      requests_seen <= n_req;
      chars_seen    <= n_char;
      locs_seen     <= n_loc;
   end

   final begin
      if (due_results.size() != 0)
         $error("%0d responses still due at end of run", due_results.size());
   end

endmodule

FILE: verif/terminal_locator_sequence_parser_tb.sv
// top of the terminal locator sequence parser testbench: clock, reset, stimulus and verdict
module terminal_locator_sequence_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned BW            = tlsp_pkg::BYTE_W;
   localparam int unsigned DW            = tlsp_pkg::DATA_W;
   localparam int unsigned HOLD_DEPTH    = 32;
   localparam int unsigned LIMIT_CYCLES  = 400000;
   localparam int unsigned SETTLE_CYCLES = 2 * HOLD_DEPTH + 8;
   localparam int unsigned STALL_CYCLES  = 300;
   localparam int unsigned PHASE_BYTES   = 55;
   localparam logic [BW-1:0] FLUSH_BYTE  = 8'h5A;

   logic          clock;
   logic          reset;
   logic          csr_we;
   logic          csr_wdata;
   logic          req_tvalid;
   logic          req_tready;
   logic [BW-1:0] req_tdata;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [DW-1:0] rsp_tdata;
   logic          rsp_tuser;
   logic          rsp_tlast;

   int unsigned fail_count;
   int unsigned pending;
   int unsigned requests_seen;
   int unsigned chars_seen;
   int unsigned locs_seen;

   logic [BW-1:0] stream_q[$];
   bit            steady;
   bit            stall_trigger;
   bit            stall_done;
   int unsigned   stall_left;
   int unsigned   cycle_count;

   terminal_locator_sequence_parser #(
      .HOLD_DEPTH(HOLD_DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   terminal_locator_report_checker #(
      .HOLD_DEPTH(HOLD_DEPTH)
   ) checker_inst (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .fail_count   (fail_count),
      .pending      (pending),
      .requests_seen(requests_seen),
      .chars_seen   (chars_seen),
      .locs_seen    (locs_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > LIMIT_CYCLES) begin
            $display("terminal_locator_sequence_parser_tb: errors");
            $finish;
         end
      end
   end

   // response side: random back-pressure, plus one long hold-off on request
   initial begin
      stall_left = 0;
      stall_done = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left == 0 && stall_trigger && !stall_done) begin
            stall_done = 1'b1;
            stall_left = STALL_CYCLES;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 38);
         end
      end
   end

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
   endtask

   task automatic add_digits(input int unsigned count);
      repeat (count) stream_q.push_back(tlsp_pkg::CH_ZERO + BW'($urandom_range(9)));
   endtask

   function automatic int unsigned digit_count();
      return ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
   endfunction

   task automatic add_report(input logic dec);
      stream_q.push_back(tlsp_pkg::CH_ESC);
      stream_q.push_back(tlsp_pkg::CH_LBR);
      if (dec) begin
         repeat (3) begin
            add_digits(digit_count());
            stream_q.push_back(tlsp_pkg::CH_SEMI);
         end
         add_digits(digit_count());
         if ($urandom_range(1)) begin
            stream_q.push_back(tlsp_pkg::CH_SEMI);
            add_digits($urandom_range(0, 3));
         end
         stream_q.push_back(tlsp_pkg::CH_AMP);
         stream_q.push_back(tlsp_pkg::CH_W);
      end else begin
         stream_q.push_back(tlsp_pkg::CH_M);
         repeat (3) stream_q.push_back(BW'($urandom_range(255)));
      end
   endtask

   // three bytes bring any open sequence to an end
   task automatic add_flush;
      repeat (3) stream_q.push_back(FLUSH_BYTE);
   endtask

   task automatic build_random(input logic dec, input int unsigned target);
      int unsigned pick;
      int unsigned start;
      int unsigned spot;
      while (stream_q.size() < target) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            add_report(dec);
         end else if (pick < 52) begin
            add_report(!dec);
         end else if (pick < 72) begin
            start = stream_q.size();
            add_report(dec);
            spot = $urandom_range(start + 1, stream_q.size() - 1);
            stream_q[spot] = BW'($urandom_range(255));
            if ($urandom_range(1))
               while (stream_q.size() > spot + 1) void'(stream_q.pop_back());
         end else begin
            repeat ($urandom_range(1, 3))
               stream_q.push_back(($urandom_range(3) == 0) ? tlsp_pkg::CH_ESC
                                                           : BW'($urandom_range(255)));
         end
      end
      add_flush();
   endtask

   task automatic send_byte(input logic [BW-1:0] b);
      while (!steady && $urandom_range(99) < 38) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_stream;
      foreach (stream_q[i]) send_byte(stream_q[i]);
      req_tvalid <= 1'b0;
      stream_q.delete();
   endtask

   task automatic drain;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_grammar(input logic dec);
      csr_we    <= 1'b1;
      csr_wdata <= dec;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = 1'b0;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      steady        = 1'b0;
      stall_trigger = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // dec grammar: plain bytes, both report forms, saturation, several ways to fail, hold overflow
      set_grammar(1'b1);
      stream_q.push_back(8'h00);
      stream_q.push_back(8'hFF);
      stream_q.push_back(tlsp_pkg::CH_SPACE);
      stream_q.push_back(tlsp_pkg::CH_ESC);
      add_text("[1;2;3;4&w");
      stream_q.push_back(tlsp_pkg::CH_ESC);
      add_text("[1;0;99999;0;&w");
      stream_q.push_back(tlsp_pkg::CH_ESC);
      add_text("[5;6;7;8;56&w");
      stream_q.push_back(tlsp_pkg::CH_ESC);
      add_text("[1;2;3;4;5x");
      stream_q.push_back(tlsp_pkg::CH_ESC);
      stream_q.push_back(tlsp_pkg::CH_ESC);
      stream_q.push_back(tlsp_pkg::CH_ESC);
      add_text("[;");
      stream_q.push_back(tlsp_pkg::CH_ESC);
      add_text("[1;2;3;&");
      stream_q.push_back(tlsp_pkg::CH_ESC);
      stream_q.push_back(tlsp_pkg::CH_LBR);
      repeat (HOLD_DEPTH - 1) stream_q.push_back(tlsp_pkg::CH_ZERO + 8'd1);
      add_flush();
      send_stream();
      drain();

      // x grammar: coordinate extremes, any bytes as coordinates, early failures
      set_grammar(1'b0);
      stream_q.push_back(tlsp_pkg::CH_ESC);
      add_text("[M");
      stream_q.push_back(tlsp_pkg::CH_SPACE);
      stream_q.push_back(8'h21);
      stream_q.push_back(8'hFF);
      stream_q.push_back(tlsp_pkg::CH_ESC);
      add_text("[M");
      repeat (3) stream_q.push_back(8'h00);
      stream_q.push_back(tlsp_pkg::CH_ESC);
      add_text("[M");
      repeat (3) stream_q.push_back(tlsp_pkg::CH_ESC);
      stream_q.push_back(tlsp_pkg::CH_ESC);
      add_text("[X");
      stream_q.push_back(tlsp_pkg::CH_ESC);
      add_text("x");
      stream_q.push_back(tlsp_pkg::CH_ESC);
      stream_q.push_back(tlsp_pkg::CH_ESC);
      add_flush();
      send_stream();
      drain();

      // no idling on either side
      steady = 1'b1;
      set_grammar(1'b1);
      build_random(1'b1, PHASE_BYTES);
      send_stream();
      drain();
      steady = 1'b0;

      // long response hold-off while requests keep coming
      set_grammar(1'b0);
      build_random(1'b0, PHASE_BYTES);
      stall_trigger = 1'b1;
      send_stream();
      drain();

      set_grammar(1'b1);
      build_random(1'b1, PHASE_BYTES);
      send_stream();
      drain();

      set_grammar(1'b0);
      build_random(1'b0, PHASE_BYTES);
      send_stream();
      drain();

      $display("covered %0d request bytes in both grammars: %0d character and %0d locator",
               requests_seen, chars_seen, locs_seen);
      $display("responses checked, with replays, hold buffer overflow and a long stall");
      if (fail_count == 0)
         $display("terminal_locator_sequence_parser_tb: clean");
      else
         $display("terminal_locator_sequence_parser_tb: errors");
      $finish;
   end

endmodule
